// File: design/lox_pkg.sv
// shared types and constants of the label outline extractor
package lox_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_BACKGROUND = 2'd1,
    CFG_WIDTH = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  localparam int OUT_BITS = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_CW = 3;

  // one result transaction
  typedef struct packed {
    logic [OUT_BITS-1:0] label;
    logic                last;
  } out_item_t;

endpackage

// File: design/lox_line_store.sv
// line store: one word per column holding that column of every ring row
module lox_line_store #(
  parameter int RING = 10,
  parameter int DEPTH = 1024,
  parameter int SW = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [$clog2(RING)-1:0]          wlane,
  input  logic [SW-1:0]                    wdata,
  input  logic                             rea,
  input  logic [$clog2(DEPTH)-1:0]         raddr_a,
  output logic [RING-1:0][SW-1:0]          rword_a,
  input  logic [$clog2(DEPTH)-1:0]         raddr_b,
  input  logic [$clog2(RING)-1:0]          rlane_b,
  output logic [SW-1:0]                    rdata_b
);

  logic [RING-1:0][SW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wlane] <= wdata;
    end
    if (rea) begin
      rword_a <= mem[raddr_a];
    end
    rdata_b <= mem[raddr_b][rlane_b];
  end

endmodule

// File: design/lox_flag_store.sv
// flag store: uniform-window bit per pixel of the ring rows
module lox_flag_store #(
  parameter int RING = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [$clog2(RING)-1:0]  wlane,
  input  logic                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  input  logic [$clog2(RING)-1:0]  rlane,
  output logic                     rdata
);

  logic [RING-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wlane] <= wdata;
    end
    rdata <= mem[raddr][rlane];
  end

endmodule

// File: design/lox_out_fifo.sv
// small result queue in front of the master-side port
module lox_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  lox_pkg::out_item_t           push_item,
  input  logic                         pop,
  output logic                         not_empty,
  output lox_pkg::out_item_t           head_item,
  output logic [lox_pkg::FIFO_CW-1:0]  count
);

  localparam int PW = $clog2(lox_pkg::FIFO_DEPTH);

  lox_pkg::out_item_t          buf_r [lox_pkg::FIFO_DEPTH];
  logic [PW-1:0]               wp_r;
  logic [PW-1:0]               rp_r;
  logic [lox_pkg::FIFO_CW-1:0] cnt_r;
  logic                        do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign not_empty = (cnt_r != '0);
  assign head_item = buf_r[rp_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_item;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + PW'(1);
      end
      case ({push, do_pop})
        2'b10: cnt_r <= cnt_r + lox_pkg::FIFO_CW'(1);
        2'b01: cnt_r <= cnt_r - lox_pkg::FIFO_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: design/label_outline_extract.sv
// top level of the label outline extractor
//
// label outline extraction over one slice in raster order: one label per
// transaction on the slave side, at most one result per transaction on the
// master side. a pixel whose label is the background gives the background;
// any other pixel gives its own label when its square window of the
// configured radius holds another label or crosses the slice edge. results
// lag the input by radius rows plus radius columns; after the last pixel of a
// slice, send flush transactions (in_tuser high) until out_tlast. the block
// takes one transaction per clock while in_tready is high; each released
// result passes both result stages. in_tready only drops while the four-entry
// result queue and the two result stages together hold four results, which
// happens only when the master side stalls. the line store is one memory word
// per column with all ring rows side by side: every pixel writes its lane and
// reads its column to test the vertical run, a second read fetches the center
// label of the result. a one-bit flag store keeps the uniform-window verdict
// for each pixel. neither memory is cleared after reset. configuration writes
// restart the slice; the user makes them only while idle; not enforced.
module label_outline_extract #(
  parameter int MAX_RADIUS = 4,
  parameter int MAX_WIDTH = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // label
  input  logic        in_tuser,   // action (1 = flush)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_label
  output logic        out_tlast,  // last_of_frame
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int RING = 2 * MAX_RADIUS + 2;
  localparam int LW = $clog2(RING);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int RUNW = $clog2(2 * MAX_RADIUS + 2);
  localparam int SW = LABEL_BITS;
  localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // configuration, kept in clamped form
  logic [RW-1:0] rad_r;
  logic [15:0]   bg_r;
  logic [WW-1:0] w_r;
  logic [15:0]   h_r;

  // positions of next input pixel and next result
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [15:0]   in_row_r, in_row_nxt;
  logic [LW-1:0] in_lane_r, in_lane_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [15:0]   out_row_r, out_row_nxt;
  logic [LW-1:0] out_lane_r, out_lane_nxt;
  logic          drain_r, drain_nxt;

  logic acc, pix, emit, last;
  logic [SW-1:0] px;
  logic [SW-1:0] bg_m;
  logic [31:0]   px_wide, bg_wide;

  // readiness window corner
  logic [16:0]   nr_sum;
  logic [15:0]   nr;
  logic [WW:0]   nc_sum;
  logic [CW-1:0] nc;
  logic          ready;

  // pixel stage
  logic          p1_v_r;
  logic [SW-1:0] p1_px_r;
  logic [15:0]   p1_row_r;
  logic [CW-1:0] p1_col_r;
  logic [LW-1:0] p1_lane_r;
  logic [RING-1:0][SW-1:0] colw;
  logic [RUNW-1:0] run_r, run_nxt;
  logic [SW-1:0]   run_val_r;
  logic            v_ok, uniform, ft_ok;
  logic [CW-1:0]   ft_col;
  logic [15:0]     ft_row;
  logic [LW-1:0]   ft_lane;

  // result stages
  logic          s1_v_r;
  logic [15:0]   s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic [LW-1:0] s1_lane_r;
  logic          s1_last_r;
  logic          s2_v_r, s2_last_r, s2_edge_r, s2_fwd_v_r, s2_fwd_flag_r;
  logic [SW-1:0] center_rd;
  logic          flag_rd;
  logic          s1_edge;

  lox_pkg::out_item_t             res_item, head_item;
  logic [lox_pkg::FIFO_CW-1:0]    fifo_cnt;
  logic [lox_pkg::FIFO_CW:0]      occ;

  assign px_wide = 32'(in_tdata);
  assign px = px_wide[SW-1:0];
  assign bg_wide = 32'(bg_r);
  assign bg_m = bg_wide[SW-1:0];

  // credit check: queue plus both result stages must fit
  assign occ = (lox_pkg::FIFO_CW+1)'(fifo_cnt) + (lox_pkg::FIFO_CW+1)'(s1_v_r)
             + (lox_pkg::FIFO_CW+1)'(s2_v_r);
  assign in_tready = (occ < (lox_pkg::FIFO_CW+1)'(lox_pkg::FIFO_DEPTH));
  assign acc = in_tvalid && in_tready;
  assign pix = acc && !in_tuser && !drain_r;

  // clamp (out_row + r, out_col + r) to the last row and column
  assign nr_sum = {1'b0, out_row_r} + 17'(rad_r);
  assign nr = (nr_sum > {1'b0, h_r - 16'd1}) ? (h_r - 16'd1) : nr_sum[15:0];
  assign nc_sum = (WW+1)'(out_col_r) + (WW+1)'(rad_r);
  assign nc = (nc_sum > {1'b0, w_r - WW'(1)}) ? CW'(w_r - WW'(1)) : nc_sum[CW-1:0];
  assign last = (out_row_r == h_r - 16'd1) && (WW'(out_col_r) == w_r - WW'(1));

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    in_lane_nxt = in_lane_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    out_lane_nxt = out_lane_r;
    drain_nxt = drain_r;
    ready = 1'b0;
    emit = 1'b0;
    if (cfg_we) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      in_lane_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      out_lane_nxt = '0;
      drain_nxt = 1'b0;
    end else if (acc) begin
      if (pix) begin
        if (WW'(in_col_r) + WW'(1) >= w_r) begin
          in_col_nxt = '0;
          if ({1'b0, in_row_r} + 17'd1 >= {1'b0, h_r}) begin
            in_row_nxt = '0;
            in_lane_nxt = '0;
            drain_nxt = 1'b1;
          end else begin
            in_row_nxt = in_row_r + 16'd1;
            in_lane_nxt = (in_lane_r == LW'(RING - 1)) ? '0 : in_lane_r + LW'(1);
          end
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end
      ready = (in_row_nxt > nr) || ((in_row_nxt == nr) && (in_col_nxt > nc));
      if (drain_nxt || ready) begin
        emit = 1'b1;
        if (last) begin
          out_col_nxt = '0;
          out_row_nxt = '0;
          out_lane_nxt = '0;
          drain_nxt = 1'b0;
        end else if (WW'(out_col_r) + WW'(1) >= w_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 16'd1;
          out_lane_nxt = (out_lane_r == LW'(RING - 1)) ? '0 : out_lane_r + LW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  // configuration and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= RW'(1);
      bg_r <= '0;
      w_r <= WW'(W_RESET);
      h_r <= 16'd1024;
      in_col_r <= '0;
      in_row_r <= '0;
      in_lane_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      out_lane_r <= '0;
      drain_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (lox_pkg::cfg_idx_t'(cfg_index))
          lox_pkg::CFG_RADIUS: begin
            rad_r <= (32'(cfg_data[2:0]) > MAX_RADIUS) ? RW'(MAX_RADIUS)
                                                         : RW'(cfg_data[2:0]);
          end
          lox_pkg::CFG_BACKGROUND: bg_r <= cfg_data;
          lox_pkg::CFG_WIDTH: begin
            if (cfg_data[10:0] == 11'd0) begin
              w_r <= WW'(1);
            end else if (32'(cfg_data[10:0]) > MAX_WIDTH) begin
              w_r <= WW'(MAX_WIDTH);
            end else begin
              w_r <= WW'(cfg_data[10:0]);
            end
          end
          lox_pkg::CFG_HEIGHT: h_r <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
          default: rad_r <= rad_r;
        endcase
      end
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      in_lane_r <= in_lane_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      out_lane_r <= out_lane_nxt;
      drain_r <= drain_nxt;
    end
  end

  lox_line_store #(.RING(RING), .DEPTH(MAX_WIDTH), .SW(SW)) u_line (
    .clk     (clk),
    .we      (pix),
    .waddr   (in_col_r),
    .wlane   (in_lane_r),
    .wdata   (px),
    .rea     (pix),
    .raddr_a (in_col_r),
    .rword_a (colw),
    .raddr_b (s1_col_r),
    .rlane_b (s1_lane_r),
    .rdata_b (center_rd)
  );

  // vertical run over rows row-2r..row of the pixel column, then the
  // horizontal run of equal uniform columns; the own pixel is merged since
  // the column was read at the edge that wrote it
  always_comb begin
    logic [LW:0]   t;
    logic [LW-1:0] lk;
    logic [SW-1:0] cellv;
    logic          all_eq;
    logic [RUNW-1:0] lim;
    all_eq = 1'b1;
    for (int k = 0; k <= 2 * MAX_RADIUS; k++) begin
      t = (LW+1)'(p1_lane_r) + (LW+1)'(RING - k);
      lk = (t >= (LW+1)'(RING)) ? LW'(t - (LW+1)'(RING)) : LW'(t);
      cellv = (k == 0) ? p1_px_r : colw[lk];
      if ((RW+1)'(k) <= {rad_r, 1'b0} && cellv != p1_px_r) begin
        all_eq = 1'b0;
      end
    end
    v_ok = p1_v_r && (p1_row_r >= 16'({rad_r, 1'b0})) && all_eq;
    lim = RUNW'({rad_r, 1'b0}) + RUNW'(1);
    if (!v_ok) begin
      run_nxt = '0;
    end else if (p1_col_r != '0 && run_r != '0 && run_val_r == p1_px_r) begin
      run_nxt = (run_r >= lim) ? lim : run_r + RUNW'(1);
    end else begin
      run_nxt = RUNW'(1);
    end
    uniform = (run_nxt >= lim);
    ft_ok = p1_v_r && (p1_row_r >= 16'(rad_r)) && (p1_col_r >= CW'(rad_r));
    ft_row = p1_row_r - 16'(rad_r);
    ft_col = p1_col_r - CW'(rad_r);
    t = (LW+1)'(p1_lane_r) + (LW+1)'(RING) - (LW+1)'(rad_r);
    ft_lane = (t >= (LW+1)'(RING)) ? LW'(t - (LW+1)'(RING)) : LW'(t);
  end

  lox_flag_store #(.RING(RING), .DEPTH(MAX_WIDTH)) u_flag (
    .clk   (clk),
    .we    (ft_ok),
    .waddr (ft_col),
    .wlane (ft_lane),
    .wdata (uniform),
    .raddr (s1_col_r),
    .rlane (s1_lane_r),
    .rdata (flag_rd)
  );

  assign s1_edge = (s1_row_r < 16'(rad_r)) || (s1_col_r < CW'(rad_r))
                || ({1'b0, s1_row_r} + 17'(rad_r) >= {1'b0, h_r})
                || ((WW+1)'(s1_col_r) + (WW+1)'(rad_r) >= {1'b0, w_r});

  // pipeline registers
  always_ff @(posedge clk) begin
    p1_px_r <= px;
    p1_row_r <= in_row_r;
    p1_col_r <= in_col_r;
    p1_lane_r <= in_lane_r;
    if (p1_v_r) begin
      run_val_r <= p1_px_r;
    end
    s1_row_r <= out_row_r;
    s1_col_r <= out_col_r;
    s1_lane_r <= out_lane_r;
    s1_last_r <= last;
    s2_last_r <= s1_last_r;
    s2_edge_r <= s1_edge;
    // the verdict written at this edge is not yet visible in the flag store
    s2_fwd_v_r <= ft_ok && (ft_row == s1_row_r) && (ft_col == s1_col_r);
    s2_fwd_flag_r <= uniform;
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      run_r <= '0;
    end else begin
      p1_v_r <= pix;
      s1_v_r <= emit;
      s2_v_r <= s1_v_r;
      if (p1_v_r) begin
        run_r <= run_nxt;
      end
    end
  end

  // result decision
  always_comb begin
    logic          flag;
    logic [SW-1:0] res;
    logic [31:0]   res_wide;
    flag = s2_fwd_v_r ? s2_fwd_flag_r : flag_rd;
    if (center_rd == bg_m || rad_r == '0) begin
      res = bg_m;
    end else if (s2_edge_r || !flag) begin
      res = center_rd;
    end else begin
      res = bg_m;
    end
    res_wide = 32'(res);
    res_item.label = res_wide[15:0];
    res_item.last = s2_last_r;
  end

  lox_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_item (res_item),
    .pop       (out_tready),
    .not_empty (out_tvalid),
    .head_item (head_item),
    .count     (fifo_cnt)
  );

  assign out_tdata = head_item.label;
  assign out_tlast = head_item.last;

`ifndef SYNTHESIS
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (WW'(in_col_r) < w_r) && (WW'(out_col_r) < w_r))
    else $error("position column beyond frame width");
  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (fifo_cnt < lox_pkg::FIFO_CW'(lox_pkg::FIFO_DEPTH)))
    else $error("result pushed into full queue");
  a_drain_origin: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (in_row_r == 16'd0) && (in_col_r == '0))
    else $error("input position moved while draining");
  a_emit_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> s1_v_r ##1 s2_v_r)
    else $error("result lost in pipeline");
`endif

endmodule

// File: bench/outline_checker.sv
// checker: predicts outline results from the observed transactions and compares them
module outline_checker #(
  parameter int MAX_RADIUS = 4,
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 2 * MAX_RADIUS + 2;

  logic [15:0] rows [RING][MAX_WIDTH];
  int unsigned in_row, in_col, out_row, out_col;
  bit          draining;
  logic [2:0]  reg_radius;
  logic [15:0] reg_bg;
  logic [10:0] reg_width;
  logic [15:0] reg_height;
  lox_pkg::out_item_t outline_q[$];

  function automatic int unsigned width_eff();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic logic [15:0] outline_of(int r, int c, int w, int h, int rad);
    logic [15:0] lab;
    lab = rows[r % RING][c % MAX_WIDTH];
    if (lab == reg_bg) return reg_bg;
    for (int dr = -rad; dr <= rad; dr++) begin
      for (int dc = -rad; dc <= rad; dc++) begin
        if (r + dr < 0 || r + dr >= h || c + dc < 0 || c + dc >= w) return lab;
        if (rows[(r + dr) % RING][(c + dc) % MAX_WIDTH] != lab) return lab;
      end
    end
    return reg_bg;
  endfunction

  // one accepted transaction: store the pixel, release a result once its window is in
  function automatic void take_pixel(logic flush, logic [15:0] lab);
    int unsigned w, h, rad, nr, nc;
    longint unsigned have, need;
    lox_pkg::out_item_t res;
    w = width_eff();
    h = (reg_height == 0) ? 1 : reg_height;
    rad = (reg_radius > MAX_RADIUS) ? MAX_RADIUS : reg_radius;
    if (in_col >= w) in_col = w - 1;
    if (in_row >= h) in_row = h - 1;
    if (out_col >= w) out_col = w - 1;
    if (out_row >= h) out_row = h - 1;
    if (!flush && !draining) begin
      rows[in_row % RING][in_col] = lab;
      if (in_col + 1 >= w) begin
        in_col = 0;
        if (in_row + 1 >= h) begin
          in_row = 0;
          draining = 1;
        end else begin
          in_row++;
        end
      end else begin
        in_col++;
      end
    end
    nr = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
    nc = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
    have = longint'(in_row) * w + in_col;
    need = longint'(nr) * w + nc;
    if (!draining && have <= need) return;
    res.label = outline_of(out_row, out_col, w, h, rad);
    res.last = (out_row == h - 1) && (out_col == w - 1);
    outline_q.push_back(res);
    if (res.last) begin
      out_row = 0;
      out_col = 0;
      draining = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  function automatic void report(string field, int exp_v, int act_v);
    if (fail_count < 10)
      $display("mismatch on %s: expected %0h, got %0h", field, exp_v, act_v);
    fail_count++;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    lox_pkg::out_item_t want;
    if (!rst_n) begin
      reg_radius = 1;
      reg_bg = 0;
      reg_width = 1024;
      reg_height = 1024;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      draining = 0;
      outline_q.delete();
    end else begin
      if (cfg_we) begin
        case (lox_pkg::cfg_idx_t'(cfg_index))
          lox_pkg::CFG_RADIUS:     reg_radius = cfg_data[2:0];
          lox_pkg::CFG_BACKGROUND: reg_bg = cfg_data;
          lox_pkg::CFG_WIDTH:      reg_width = cfg_data[10:0];
          lox_pkg::CFG_HEIGHT:     reg_height = cfg_data;
          default:                 reg_height = reg_height;
        endcase
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        draining = 0;
      end
      if (in_tvalid && in_tready) take_pixel(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (outline_q.size() == 0) begin
          report("unexpected result label", 0, out_tdata);
        end else begin
          want = outline_q.pop_front();
          if (want.label !== out_tdata) report("out_label", want.label, out_tdata);
          if (want.last !== out_tlast) report("last_of_frame", want.last, out_tlast);
        end
      end
    end
    pending <= outline_q.size();
  end

endmodule

// File: bench/testbench.sv
// top of the bench: stimulus for the label outline extractor and the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = 0;   // label
  logic        in_tuser = 0;   // action (1 = flush)
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;      // out_label
  logic        out_tlast;      // last_of_frame
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;
  int          fail_count;
  int          pending;

  // idling percentages of the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // slice bookkeeping so the stimulus knows when to stop flushing
  int unsigned     sl_w, sl_h, sl_r;
  longint unsigned pix_fed, res_made;
  bit              sl_draining, sl_done;
  int              pixel_count = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  label_outline_extract dut (.*);

  outline_checker chk (.*);

  // receiver stalls at random
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // limit on the whole run
  initial begin
    #2_500_000;
    $display("Verification failed");
    $finish;
  end

  // mirror of the slice position: tells when the last result of a slice is released
  function automatic void track(bit flush);
    longint unsigned need, orow, ocol, nr, nc;
    if (!flush && !sl_draining) begin
      pix_fed++;
      if (pix_fed == longint'(sl_w) * sl_h) sl_draining = 1;
    end
    orow = res_made / sl_w;
    ocol = res_made % sl_w;
    nr = (orow + sl_r > sl_h - 1) ? sl_h - 1 : orow + sl_r;
    nc = (ocol + sl_r > sl_w - 1) ? sl_w - 1 : ocol + sl_r;
    need = nr * sl_w + nc;
    if (sl_draining || pix_fed > need) begin
      res_made++;
      if (res_made == longint'(sl_w) * sl_h) begin
        sl_draining = 0;
        sl_done = 1;
      end
    end
  endfunction

  // one transaction on the slave side; tvalid stays up for a following one
  task automatic send(bit flush, logic [15:0] lab);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1;
    in_tuser <= flush;
    in_tdata <= lab;
    do @(posedge clk); while (!in_tready);
    track(flush);
    if (!flush) pixel_count++;
  endtask

  // wait until every expected result has come, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // all four registers, only while idle
  task automatic configure(logic [2:0] rad, logic [15:0] bg, logic [15:0] w, logic [15:0] h);
    lox_pkg::cfg_idx_t idx;
    logic [15:0] val;
    for (int i = 0; i < 4; i++) begin
      idx = lox_pkg::cfg_idx_t'(i);
      case (idx)
        lox_pkg::CFG_RADIUS:     val = 16'(rad);
        lox_pkg::CFG_BACKGROUND: val = bg;
        lox_pkg::CFG_WIDTH:      val = w;
        default:                 val = h;
      endcase
      cfg_we <= 1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
    end
    cfg_we <= 0;
    sl_r = (rad > 4) ? 4 : rad;
    sl_w = (w[10:0] == 0) ? 1 : (w[10:0] > 1024) ? 1024 : w[10:0];
    sl_h = (h == 0) ? 1 : h;
    pix_fed = 0;
    res_made = 0;
    sl_draining = 0;
    sl_done = 0;
  endtask

  // flushes until the last result; now and then a pixel that the block drops
  task automatic drain_slice();
    while (!sl_done) begin
      if ($urandom_range(99) < 10) send(0, 16'($urandom));
      else send(1, 16'($urandom));
    end
  endtask

  // random slice built from a few rectangular regions with some noise
  task automatic random_slice();
    logic [15:0] bg, pa, pb, pc, lab;
    logic [15:0] w, h;
    int unsigned split_c, split_r;
    bg = ($urandom_range(1)) ? 16'($urandom_range(3)) : 16'($urandom);
    pa = ($urandom_range(1)) ? 16'($urandom_range(5)) : 16'($urandom);
    pb = ($urandom_range(1)) ? bg : 16'($urandom);
    pc = 16'($urandom);
    case ($urandom_range(19))
      0:       begin w = 0; h = 16'($urandom_range(8)); end
      1:       begin
        w = 16'($urandom_range(1, 10)) | 16'($urandom & 16'hf800);
        h = 16'($urandom_range(1, 8));
      end
      2:       begin w = 16'($urandom_range(1, 10)); h = 0; end
      default: begin w = 16'($urandom_range(1, 10)); h = 16'($urandom_range(1, 8)); end
    endcase
    configure(3'($urandom_range(7)), bg, w, h);
    split_c = $urandom_range(sl_w);
    split_r = $urandom_range(sl_h);
    for (int r = 0; r < sl_h; r++) begin
      for (int c = 0; c < sl_w; c++) begin
        if ($urandom_range(99) < 8) lab = 16'($urandom);
        else if (c < split_c) lab = (r < split_r) ? pa : pb;
        else lab = (r < split_r) ? pc : pa;
        if ($urandom_range(99) < 6) send(1, 16'($urandom));
        send(0, lab);
      end
    end
    drain_slice();
    wait_idle();
  endtask

  initial begin
    logic [15:0] corner [9];
    corner = '{16'hffff, 16'hffff, 16'h0000,
               16'h8000, 16'hffff, 16'hffff,
               16'h0001, 16'hffff, 16'hffff};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: 3x3 slice with extreme labels, a flush before any result is ready,
    // then flushes with a dropped pixel while draining
    configure(1, 16'h0000, 3, 3);
    send(1, 16'hffff);
    foreach (corner[i]) send(0, corner[i]);
    send(0, 16'h1234);
    drain_slice();
    wait_idle();

    // a 5x5 uniform slice: only the inner 3x3 pixels are off the outline
    configure(1, 16'h0007, 5, 5);
    for (int i = 0; i < 25; i++) send(0, 16'h0042);
    drain_slice();
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (ph == 0) begin
        // largest height, radius above the limit, column one pixel wide; only the
        // top rows are fed, the next configuration restarts the slice
        configure(3'd7, 16'hffff, 16'd1, 16'hffff);
        for (int i = 0; i < 48; i++) send(0, ($urandom_range(99) < 90) ? 16'h0 : 16'hffff);
        wait_idle();
        // width above the limit gives the widest row; radius zero never marks an outline
        configure(3'd0, 16'h0000, 16'd2047, 16'd2);
        for (int i = 0; i < 48; i++) send(0, 16'($urandom));
        wait_idle();
        pixel_count = 0;
      end
      while (pixel_count < (ph + 1) * 275) random_slice();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
